/* sv/grdcs_pkg.sv */
// ----------------------------------------------------------------------------
// grdcs_pkg: shared definitions for the gradient color stop resolver
// Sizes, register indexes, controller states and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package grdcs_pkg;

	// sizes
	localparam int MAX_STOPS = 16;
	localparam int FRAC_BITS = 16;
	localparam int OFF_W = 32;
	localparam int COL_W = 32;
	localparam int LEN_W = 31;
	localparam int IDX_W = $clog2(MAX_STOPS);
	localparam int CNT_W = $clog2(MAX_STOPS + 1);
	localparam int NUM_W = 33 + FRAC_BITS;
	localparam int DEN_W = 32;
	localparam int QCNT_W = $clog2(NUM_W + 1);
	localparam int CFG_IDX_W = 1;

	localparam logic signed [OFF_W-1:0] FX_ONE = 32'sh1 <<< FRAC_BITS;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MODE = 1'd1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_EMPTY0,
		ST_EMPTY1,
		ST_P1,
		ST_P1_DIV,
		ST_P2,
		ST_P2_MUL,
		ST_P2_DIVGO,
		ST_P2_DIV,
		ST_P3_S0,
		ST_P3_S1,
		ST_P3,
		ST_P3_DIV,
		ST_P4_PRE,
		ST_P4_POST,
		ST_EM_PRE,
		ST_EM_STOP,
		ST_EM_POST
	} state_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_P1_FIX,
		OP_P1_DIV_GO,
		OP_P1_DIV_WB,
		OP_P2_TRACK,
		OP_P2_DIFF,
		OP_P2_MUL,
		OP_P2_DIV_GO,
		OP_P2_WB,
		OP_P3_S0,
		OP_P3_S1,
		OP_P3_DIV_GO,
		OP_P3_WB,
		OP_P4_PRE,
		OP_P4_POST,
		OP_OUT_EMPTY0,
		OP_OUT_EMPTY1,
		OP_OUT_PRE,
		OP_OUT_STOP,
		OP_OUT_POST
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [IDX_W-1:0] idx;
		logic first;
		logic is_end;
		logic multi;
		logic [CNT_W-1:0] k;
		logic [CNT_W-1:0] parts;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic valued;
		logic need_div;
		logic div_done;
		logic resc;
		logic span_pos;
		logic pre;
		logic post;
		logic out_free;
	} status_t;

endpackage

/* sv/grdcs_div.sv */
// ----------------------------------------------------------------------------
// grdcs_div: unsigned restoring divider
// One quotient bit per cycle; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module grdcs_div (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic [grdcs_pkg::NUM_W-1:0] num,
	input  logic [grdcs_pkg::DEN_W-1:0] den,
	output logic done,
	output logic [grdcs_pkg::NUM_W-1:0] quot
);

	logic busy_q;
	logic done_q;
	logic [grdcs_pkg::QCNT_W-1:0] cnt_q;
	logic [grdcs_pkg::NUM_W-1:0] acc_q;
	logic [grdcs_pkg::DEN_W-1:0] rem_q;
	logic [grdcs_pkg::DEN_W-1:0] den_q;
	logic [grdcs_pkg::DEN_W:0] trial;
	logic [grdcs_pkg::DEN_W:0] sub;
	logic ge;

	// trial subtraction
	assign trial = {rem_q, acc_q[grdcs_pkg::NUM_W-1]};
	assign sub = trial - {1'b0, den_q};
	assign ge = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= grdcs_pkg::QCNT_W'(grdcs_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == grdcs_pkg::QCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend, quotient and remainder
	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			acc_q <= {acc_q[grdcs_pkg::NUM_W-2:0], ge};
			rem_q <= ge ? sub[grdcs_pkg::DEN_W-1:0] : trial[grdcs_pkg::DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = acc_q;

endmodule

/* sv/grdcs_dpath.sv */
// ----------------------------------------------------------------------------
// grdcs_dpath: datapath of the gradient color stop resolver
// Stop storage, configuration registers, offset arithmetic, the shared
// divider and the output register.
// ----------------------------------------------------------------------------
module grdcs_dpath (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [grdcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [grdcs_pkg::LEN_W-1:0] cfg_wdata,
	input  logic signed [grdcs_pkg::OFF_W-1:0] stop_offset,
	input  logic offset_given,
	input  logic offset_in_pixels,
	input  logic [grdcs_pkg::COL_W-1:0] stop_color,
	input  grdcs_pkg::cmd_t cmd,
	output grdcs_pkg::status_t status,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [grdcs_pkg::OFF_W-1:0] position,
	output logic [grdcs_pkg::COL_W-1:0] color,
	output logic last_entry,
	output logic rescaled,
	output logic signed [grdcs_pkg::OFF_W-1:0] span_start,
	output logic signed [grdcs_pkg::OFF_W-1:0] span_end
);

	localparam int PROD_W = 34 + grdcs_pkg::CNT_W;

	function automatic logic signed [grdcs_pkg::OFF_W-1:0] sat32(
		input logic signed [grdcs_pkg::NUM_W:0] v);
		logic [grdcs_pkg::NUM_W-31:0] top;
		top = v[grdcs_pkg::NUM_W:31];
		if (top == '0 || top == '1)
			return v[31:0];
		return v[grdcs_pkg::NUM_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
	endfunction

	// stop storage
	logic signed [grdcs_pkg::OFF_W-1:0] off_mem [grdcs_pkg::MAX_STOPS];
	logic [grdcs_pkg::COL_W-1:0] col_mem [grdcs_pkg::MAX_STOPS];
	logic valued_mem [grdcs_pkg::MAX_STOPS];
	logic pix_mem [grdcs_pkg::MAX_STOPS];

	logic [grdcs_pkg::LEN_W-1:0] len_q;
	logic repeat_q;
	logic signed [grdcs_pkg::OFF_W-1:0] prev_q;
	logic signed [grdcs_pkg::OFF_W-1:0] base_q;
	logic signed [32:0] diff_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [grdcs_pkg::OFF_W-1:0] s0_q;
	logic signed [grdcs_pkg::OFF_W-1:0] s1_q;
	logic resc_q;
	logic pre_q;
	logic post_q;
	logic div_neg_q;

	logic out_valid_q;
	logic signed [grdcs_pkg::OFF_W-1:0] pos_q;
	logic [grdcs_pkg::COL_W-1:0] col_q;
	logic last_q;
	logic resc_out_q;
	logic signed [grdcs_pkg::OFF_W-1:0] span0_q;
	logic signed [grdcs_pkg::OFF_W-1:0] span1_q;

	logic signed [grdcs_pkg::OFF_W-1:0] rd_off;
	logic [grdcs_pkg::COL_W-1:0] rd_col;
	logic rd_valued;
	logic rd_pix;
	logic len_pos;
	logic out_free;

	logic div_go;
	logic div_done;
	logic div_neg_d;
	logic [grdcs_pkg::NUM_W-1:0] div_num;
	logic [grdcs_pkg::DEN_W-1:0] div_den;
	logic [grdcs_pkg::NUM_W-1:0] quot;
	logic signed [grdcs_pkg::NUM_W:0] q_s;

	logic [grdcs_pkg::OFF_W-1:0] off_mag;
	logic signed [32:0] rel;
	logic signed [32:0] span;
	logic [PROD_W-1:0] prod_mag;

	logic new_valued;
	logic signed [grdcs_pkg::OFF_W-1:0] fix_val;
	logic signed [grdcs_pkg::OFF_W-1:0] clamp_val;
	logic signed [grdcs_pkg::NUM_W:0] fill_sum;

	logic wr_off;
	logic wr_valued;
	logic signed [grdcs_pkg::OFF_W-1:0] wr_off_val;

	// read port
	assign rd_off = off_mem[cmd.idx];
	assign rd_col = col_mem[cmd.idx];
	assign rd_valued = valued_mem[cmd.idx];
	assign rd_pix = pix_mem[cmd.idx];
	assign len_pos = len_q != '0;
	assign out_free = !out_valid_q || out_ready;

	// signed quotient and helper values
	assign q_s = div_neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
	assign off_mag = rd_off[grdcs_pkg::OFF_W-1] ? 32'(-rd_off) : 32'(rd_off);
	assign rel = 33'(rd_off) - 33'(s0_q);
	assign span = 33'(s1_q) - 33'(s0_q);
	assign prod_mag = prod_s1[PROD_W-1] ? PROD_W'(-prod_s1) : PROD_W'(prod_s1);
	assign fill_sum = (grdcs_pkg::NUM_W+1)'(base_q) + q_s;

	// offset fix-up and forward clamp
	always_comb begin
		new_valued = rd_valued || cmd.first || (cmd.is_end && cmd.multi);
		if (rd_valued)
			fix_val = rd_pix ? '0 : rd_off;
		else if (cmd.first)
			fix_val = '0;
		else if (cmd.is_end && cmd.multi)
			fix_val = grdcs_pkg::FX_ONE;
		else
			fix_val = rd_off;
		if (cmd.op == grdcs_pkg::OP_P1_DIV_WB)
			fix_val = sat32(q_s);
		clamp_val = (!cmd.first && fix_val < prev_q) ? prev_q : fix_val;
	end

	// divider operands
	always_comb begin
		div_go = 1'b0;
		div_neg_d = 1'b0;
		div_num = '0;
		div_den = '0;
		case (cmd.op)
			grdcs_pkg::OP_P1_DIV_GO: begin
				div_go = 1'b1;
				div_neg_d = rd_off[grdcs_pkg::OFF_W-1];
				div_num = grdcs_pkg::NUM_W'(off_mag) << grdcs_pkg::FRAC_BITS;
				div_den = grdcs_pkg::DEN_W'(len_q);
			end
			grdcs_pkg::OP_P2_DIV_GO: begin
				div_go = 1'b1;
				div_neg_d = prod_s1[PROD_W-1];
				div_num = grdcs_pkg::NUM_W'(prod_mag);
				div_den = grdcs_pkg::DEN_W'(cmd.parts);
			end
			grdcs_pkg::OP_P3_DIV_GO: begin
				div_go = 1'b1;
				div_num = rel[32] ? '0 :
					(grdcs_pkg::NUM_W'(rel[32:0]) << grdcs_pkg::FRAC_BITS);
				div_den = span[grdcs_pkg::DEN_W-1:0];
			end
			default: begin
				div_go = 1'b0;
			end
		endcase
	end

	// storage write selection
	always_comb begin
		wr_off = 1'b0;
		wr_valued = 1'b0;
		wr_off_val = clamp_val;
		case (cmd.op)
			grdcs_pkg::OP_P1_FIX: begin
				wr_off = new_valued;
				wr_valued = new_valued;
			end
			grdcs_pkg::OP_P1_DIV_WB: begin
				wr_off = 1'b1;
			end
			grdcs_pkg::OP_P2_WB: begin
				wr_off = 1'b1;
				wr_valued = 1'b1;
				wr_off_val = fill_sum[grdcs_pkg::OFF_W-1:0];
			end
			grdcs_pkg::OP_P3_WB: begin
				wr_off = 1'b1;
				wr_off_val = sat32(q_s);
			end
			default: begin
				wr_off = 1'b0;
			end
		endcase
	end

	// stop storage writes
	always_ff @(posedge clk) begin
		if (cmd.op == grdcs_pkg::OP_LOAD) begin
			off_mem[cmd.idx] <= stop_offset;
			col_mem[cmd.idx] <= stop_color;
			valued_mem[cmd.idx] <= offset_given;
			pix_mem[cmd.idx] <= offset_in_pixels;
		end else begin
			if (wr_off)
				off_mem[cmd.idx] <= wr_off_val;
			if (wr_valued)
				valued_mem[cmd.idx] <= 1'b1;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			repeat_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				grdcs_pkg::REG_GRADIENT_LENGTH: len_q <= cfg_wdata;
				grdcs_pkg::REG_REPEAT_MODE: repeat_q <= cfg_wdata[0];
				default: len_q <= len_q;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (div_go)
			div_neg_q <= div_neg_d;
		case (cmd.op)
			grdcs_pkg::OP_P1_FIX: begin
				if (new_valued)
					prev_q <= clamp_val;
			end
			grdcs_pkg::OP_P1_DIV_WB: prev_q <= clamp_val;
			grdcs_pkg::OP_P2_TRACK: base_q <= rd_off;
			grdcs_pkg::OP_P2_DIFF: diff_q <= 33'(rd_off) - 33'(base_q);
			grdcs_pkg::OP_P2_MUL: prod_s1 <= PROD_W'(diff_q * $signed({1'b0, cmd.k}));
			grdcs_pkg::OP_P3_S0: s0_q <= rd_off;
			grdcs_pkg::OP_P3_S1: s1_q <= rd_off;
			grdcs_pkg::OP_P4_PRE: pre_q <= rd_off > 0;
			grdcs_pkg::OP_P4_POST: post_q <= rd_off < grdcs_pkg::FX_ONE;
			default: begin
				base_q <= base_q;
			end
		endcase
	end

	// rescale decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			resc_q <= 1'b0;
		else if (cmd.op == grdcs_pkg::OP_P3_S1)
			resc_q <= cmd.multi && (repeat_q || s0_q < 0 || rd_off > grdcs_pkg::FX_ONE);
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == grdcs_pkg::OP_OUT_EMPTY0 || cmd.op == grdcs_pkg::OP_OUT_EMPTY1 ||
				cmd.op == grdcs_pkg::OP_OUT_PRE || cmd.op == grdcs_pkg::OP_OUT_STOP ||
				cmd.op == grdcs_pkg::OP_OUT_POST)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			grdcs_pkg::OP_OUT_EMPTY0, grdcs_pkg::OP_OUT_EMPTY1: begin
				pos_q <= (cmd.op == grdcs_pkg::OP_OUT_EMPTY1) ? grdcs_pkg::FX_ONE : '0;
				col_q <= '0;
				last_q <= cmd.last;
				resc_out_q <= 1'b0;
				span0_q <= '0;
				span1_q <= '0;
			end
			grdcs_pkg::OP_OUT_PRE, grdcs_pkg::OP_OUT_STOP, grdcs_pkg::OP_OUT_POST: begin
				case (cmd.op)
					grdcs_pkg::OP_OUT_PRE: pos_q <= '0;
					grdcs_pkg::OP_OUT_POST: pos_q <= grdcs_pkg::FX_ONE;
					default: pos_q <= rd_off;
				endcase
				col_q <= rd_col;
				last_q <= cmd.last;
				resc_out_q <= resc_q;
				span0_q <= s0_q;
				span1_q <= s1_q;
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	grdcs_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(div_go),
		.num(div_num),
		.den(div_den),
		.done(div_done),
		.quot(quot)
	);

	// status to the controller
	always_comb begin
		status.valued = rd_valued;
		status.need_div = rd_valued && rd_pix && len_pos;
		status.div_done = div_done;
		status.resc = resc_q;
		status.span_pos = span > 0;
		status.pre = pre_q;
		status.post = post_q;
		status.out_free = out_free;
	end

	assign out_valid = out_valid_q;
	assign position = pos_q;
	assign color = col_q;
	assign last_entry = last_q;
	assign rescaled = resc_out_q;
	assign span_start = span0_q;
	assign span_end = span1_q;

endmodule

/* sv/grdcs_ctrl.sv */
// ----------------------------------------------------------------------------
// grdcs_ctrl: controller of the gradient color stop resolver
// Walks the stop list through load, fix-up, even spacing, rescale and
// emission, and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module grdcs_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic list_empty,
	input  logic last_stop,
	input  grdcs_pkg::status_t status,
	output grdcs_pkg::cmd_t cmd
);

	grdcs_pkg::state_t state_q, state_d;
	logic [grdcs_pkg::IDX_W-1:0] i_q, i_d;
	logic [grdcs_pkg::IDX_W-1:0] j_q, j_d;
	logic [grdcs_pkg::IDX_W-1:0] start_q, start_d;
	logic [grdcs_pkg::CNT_W-1:0] count_q, count_d;
	logic run_q, run_d;

	logic is_end;
	logic full;
	logic run_done;
	logic [grdcs_pkg::CNT_W-1:0] cnt_m1;
	logic [grdcs_pkg::IDX_W-1:0] last_idx;

	assign is_end = grdcs_pkg::CNT_W'(i_q) + grdcs_pkg::CNT_W'(1) == count_q;
	assign full = count_q == grdcs_pkg::CNT_W'(grdcs_pkg::MAX_STOPS);
	assign run_done = grdcs_pkg::CNT_W'(j_q) + grdcs_pkg::CNT_W'(1) == grdcs_pkg::CNT_W'(i_q);
	assign cnt_m1 = count_q - grdcs_pkg::CNT_W'(1);
	assign last_idx = cnt_m1[grdcs_pkg::IDX_W-1:0];

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grdcs_pkg::ST_IDLE;
			i_q <= '0;
			j_q <= '0;
			start_q <= '0;
			count_q <= '0;
			run_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			j_q <= j_d;
			start_q <= start_d;
			count_q <= count_d;
			run_q <= run_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		i_d = i_q;
		j_d = j_q;
		start_d = start_q;
		count_d = count_q;
		run_d = run_q;
		in_ready = 1'b0;
		cmd.op = grdcs_pkg::OP_NOP;
		cmd.idx = i_q;
		cmd.first = i_q == '0;
		cmd.is_end = is_end;
		cmd.multi = count_q > grdcs_pkg::CNT_W'(1);
		cmd.k = grdcs_pkg::CNT_W'(j_q) - grdcs_pkg::CNT_W'(start_q) + grdcs_pkg::CNT_W'(1);
		cmd.parts = grdcs_pkg::CNT_W'(i_q) - grdcs_pkg::CNT_W'(start_q) + grdcs_pkg::CNT_W'(1);
		cmd.last = 1'b0;
		case (state_q)
			grdcs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (list_empty) begin
						count_d = '0;
						state_d = grdcs_pkg::ST_EMPTY0;
					end else begin
						if (!full) begin
							cmd.op = grdcs_pkg::OP_LOAD;
							cmd.idx = count_q[grdcs_pkg::IDX_W-1:0];
							count_d = count_q + grdcs_pkg::CNT_W'(1);
						end
						if (last_stop) begin
							i_d = '0;
							state_d = grdcs_pkg::ST_P1;
						end
					end
				end
			end
			grdcs_pkg::ST_EMPTY0: begin
				if (status.out_free) begin
					cmd.op = grdcs_pkg::OP_OUT_EMPTY0;
					state_d = grdcs_pkg::ST_EMPTY1;
				end
			end
			grdcs_pkg::ST_EMPTY1: begin
				if (status.out_free) begin
					cmd.op = grdcs_pkg::OP_OUT_EMPTY1;
					cmd.last = 1'b1;
					state_d = grdcs_pkg::ST_IDLE;
				end
			end
			// fix-up pass with forward clamp
			grdcs_pkg::ST_P1, grdcs_pkg::ST_P1_DIV: begin
				if (state_q == grdcs_pkg::ST_P1 && status.need_div) begin
					cmd.op = grdcs_pkg::OP_P1_DIV_GO;
					state_d = grdcs_pkg::ST_P1_DIV;
				end else if (state_q == grdcs_pkg::ST_P1 || status.div_done) begin
					cmd.op = (state_q == grdcs_pkg::ST_P1) ? grdcs_pkg::OP_P1_FIX :
						grdcs_pkg::OP_P1_DIV_WB;
					if (is_end) begin
						i_d = '0;
						run_d = 1'b0;
						state_d = grdcs_pkg::ST_P2;
					end else begin
						i_d = i_q + 1'b1;
						state_d = grdcs_pkg::ST_P1;
					end
				end
			end
			// scan for runs of missing offsets
			grdcs_pkg::ST_P2: begin
				if (status.valued && run_q) begin
					cmd.op = grdcs_pkg::OP_P2_DIFF;
					j_d = start_q;
					state_d = grdcs_pkg::ST_P2_MUL;
				end else begin
					if (status.valued) begin
						cmd.op = grdcs_pkg::OP_P2_TRACK;
					end else if (!run_q) begin
						start_d = i_q;
						run_d = 1'b1;
					end
					if (is_end)
						state_d = grdcs_pkg::ST_P3_S0;
					else
						i_d = i_q + 1'b1;
				end
			end
			grdcs_pkg::ST_P2_MUL: begin
				cmd.idx = j_q;
				cmd.op = grdcs_pkg::OP_P2_MUL;
				state_d = grdcs_pkg::ST_P2_DIVGO;
			end
			grdcs_pkg::ST_P2_DIVGO: begin
				cmd.idx = j_q;
				cmd.op = grdcs_pkg::OP_P2_DIV_GO;
				state_d = grdcs_pkg::ST_P2_DIV;
			end
			grdcs_pkg::ST_P2_DIV: begin
				cmd.idx = j_q;
				if (status.div_done) begin
					cmd.op = grdcs_pkg::OP_P2_WB;
					if (run_done) begin
						run_d = 1'b0;
						state_d = grdcs_pkg::ST_P2;
					end else begin
						j_d = j_q + 1'b1;
						state_d = grdcs_pkg::ST_P2_MUL;
					end
				end
			end
			// span capture and rescale
			grdcs_pkg::ST_P3_S0: begin
				cmd.idx = '0;
				cmd.op = grdcs_pkg::OP_P3_S0;
				state_d = grdcs_pkg::ST_P3_S1;
			end
			grdcs_pkg::ST_P3_S1: begin
				cmd.idx = last_idx;
				cmd.op = grdcs_pkg::OP_P3_S1;
				i_d = '0;
				state_d = grdcs_pkg::ST_P3;
			end
			grdcs_pkg::ST_P3: begin
				if (status.resc && status.span_pos) begin
					cmd.op = grdcs_pkg::OP_P3_DIV_GO;
					state_d = grdcs_pkg::ST_P3_DIV;
				end else begin
					state_d = grdcs_pkg::ST_P4_PRE;
				end
			end
			grdcs_pkg::ST_P3_DIV: begin
				if (status.div_done) begin
					cmd.op = grdcs_pkg::OP_P3_WB;
					if (is_end) begin
						state_d = grdcs_pkg::ST_P4_PRE;
					end else begin
						i_d = i_q + 1'b1;
						state_d = grdcs_pkg::ST_P3;
					end
				end
			end
			// padding decisions
			grdcs_pkg::ST_P4_PRE: begin
				cmd.idx = '0;
				cmd.op = grdcs_pkg::OP_P4_PRE;
				state_d = grdcs_pkg::ST_P4_POST;
			end
			grdcs_pkg::ST_P4_POST: begin
				cmd.idx = last_idx;
				cmd.op = grdcs_pkg::OP_P4_POST;
				i_d = '0;
				state_d = grdcs_pkg::ST_EM_PRE;
			end
			// emission
			grdcs_pkg::ST_EM_PRE: begin
				cmd.idx = '0;
				if (!status.pre) begin
					state_d = grdcs_pkg::ST_EM_STOP;
				end else if (status.out_free) begin
					cmd.op = grdcs_pkg::OP_OUT_PRE;
					state_d = grdcs_pkg::ST_EM_STOP;
				end
			end
			grdcs_pkg::ST_EM_STOP: begin
				if (status.out_free) begin
					cmd.op = grdcs_pkg::OP_OUT_STOP;
					cmd.last = is_end && !status.post;
					if (!is_end) begin
						i_d = i_q + 1'b1;
					end else if (status.post) begin
						state_d = grdcs_pkg::ST_EM_POST;
					end else begin
						count_d = '0;
						state_d = grdcs_pkg::ST_IDLE;
					end
				end
			end
			grdcs_pkg::ST_EM_POST: begin
				cmd.idx = last_idx;
				if (status.out_free) begin
					cmd.op = grdcs_pkg::OP_OUT_POST;
					cmd.last = 1'b1;
					count_d = '0;
					state_d = grdcs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = grdcs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/gradient_color_stop_resolve_core.sv */
// A non-final stop is taken while idle; a final stop starts a resolve pass.
// Resolve: the stops are scanned in turn; pixel offsets, evenly spaced stops and rescaled
// stops each wait on the shared 49-step divider (one quotient bit per cycle). Entries
// then leave one per cycle while out_ready is held high.
// Reset clears the configuration, the stop count, the controller and the output
// valid; the stop storage is not cleared.
// ----------------------------------------------------------------------------
// gradient_color_stop_resolve_core: gradient color stop resolver
// Collects the color stops of one gradient, resolves their offsets and emits
// the (position, color) entries of the resolved list.
// ----------------------------------------------------------------------------
module gradient_color_stop_resolve_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [grdcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [grdcs_pkg::LEN_W-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [grdcs_pkg::OFF_W-1:0] stop_offset,
	input  logic offset_given,
	input  logic offset_in_pixels,
	input  logic [grdcs_pkg::COL_W-1:0] stop_color,
	input  logic list_empty,
	input  logic last_stop,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [grdcs_pkg::OFF_W-1:0] position,
	output logic [grdcs_pkg::COL_W-1:0] color,
	output logic last_entry,
	output logic rescaled,
	output logic signed [grdcs_pkg::OFF_W-1:0] span_start,
	output logic signed [grdcs_pkg::OFF_W-1:0] span_end
);

	grdcs_pkg::cmd_t cmd;
	grdcs_pkg::status_t status;

	grdcs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.list_empty(list_empty),
		.last_stop(last_stop),
		.status(status),
		.cmd(cmd)
	);

	grdcs_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.stop_offset(stop_offset),
		.offset_given(offset_given),
		.offset_in_pixels(offset_in_pixels),
		.stop_color(stop_color),
		.cmd(cmd),
		.status(status),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.position(position),
		.color(color),
		.last_entry(last_entry),
		.rescaled(rescaled),
		.span_start(span_start),
		.span_end(span_end)
	);

	// a stop is stored only on an accepted input transaction
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == grdcs_pkg::OP_LOAD |-> in_valid && in_ready)
		else $error("stop stored without an input transaction");

	// the output register is loaded only when it is free
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == grdcs_pkg::OP_OUT_PRE || cmd.op == grdcs_pkg::OP_OUT_STOP ||
		cmd.op == grdcs_pkg::OP_OUT_POST || cmd.op == grdcs_pkg::OP_OUT_EMPTY0 ||
		cmd.op == grdcs_pkg::OP_OUT_EMPTY1) |-> status.out_free)
		else $error("output register overwritten");

	// divider completion is a single-cycle pulse
	a_div_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |=> !status.div_done)
		else $error("divider done held");

	// no new stop is taken while a stop entry is loaded into the output register
	a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == grdcs_pkg::OP_OUT_STOP |-> !in_ready)
		else $error("input accepted during emission");

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for gradient_color_stop_resolve_core
// Stop lists (directed corner cases, then random lists) are driven under
// random input gaps and output stalls. A built-in predictor resolves each
// list, and every emitted entry is compared field by field with the oldest
// expected entry.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam longint ONE = 64'sd1 << grdcs_pkg::FRAC_BITS;

	typedef struct {
		logic signed [grdcs_pkg::OFF_W-1:0] offset;
		logic given;
		logic pixels;
		logic [grdcs_pkg::COL_W-1:0] col;
		logic empty;
		logic last;
	} stop_item_t;

	typedef struct {
		logic signed [grdcs_pkg::OFF_W-1:0] pos;
		logic [grdcs_pkg::COL_W-1:0] col;
		logic last;
		logic resc;
		logic signed [grdcs_pkg::OFF_W-1:0] s0;
		logic signed [grdcs_pkg::OFF_W-1:0] s1;
	} color_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [grdcs_pkg::CFG_IDX_W-1:0] cfg_index = grdcs_pkg::REG_GRADIENT_LENGTH;
	logic [grdcs_pkg::LEN_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [grdcs_pkg::OFF_W-1:0] stop_offset = '0;
	logic offset_given = 1'b0;
	logic offset_in_pixels = 1'b0;
	logic [grdcs_pkg::COL_W-1:0] stop_color = '0;
	logic list_empty = 1'b0;
	logic last_stop = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [grdcs_pkg::OFF_W-1:0] position;
	logic [grdcs_pkg::COL_W-1:0] color;
	logic last_entry;
	logic rescaled;
	logic signed [grdcs_pkg::OFF_W-1:0] span_start;
	logic signed [grdcs_pkg::OFF_W-1:0] span_end;

	stop_item_t pending_stops[$];
	color_entry_t expected_entries[$];
	int errors = 0;
	int cycles = 0;
	bit no_idle = 1'b0;
	int in_gap = 0;
	int out_stall = 0;

	// predictor state
	longint held_off[grdcs_pkg::MAX_STOPS];
	logic [grdcs_pkg::COL_W-1:0] held_col[grdcs_pkg::MAX_STOPS];
	bit held_valued[grdcs_pkg::MAX_STOPS];
	bit held_pixels[grdcs_pkg::MAX_STOPS];
	int held_count = 0;
	longint cfg_length = 0;
	bit cfg_repeat = 1'b0;

	gradient_color_stop_resolve_core uut (.*);

	always #10 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic void push_entry(longint pos, logic [grdcs_pkg::COL_W-1:0] col, bit last,
			bit resc, longint s0, longint s1);
		color_entry_t e;
		e.pos = clamp32(pos);
		e.col = col;
		e.last = last;
		e.resc = resc;
		e.s0 = clamp32(s0);
		e.s1 = clamp32(s1);
		expected_entries.insert(expected_entries.size(), e);
	endfunction

	// resolve the held stops into expected entries
	function automatic void resolve_stop_list();
		int n;
		int start;
		int total;
		int k;
		bit in_run;
		bit have_prev;
		bit resc;
		bit pre;
		bit post;
		longint prev;
		longint b;
		longint diff;
		longint s0;
		longint s1;
		longint span;
		longint rel;
		n = held_count;
		have_prev = 0;
		prev = 0;
		resc = 0;
		// fix-up scan: pixels, missing endpoints, monotonic clamp
		for (int i = 0; i < n; i++) begin
			if (held_valued[i]) begin
				if (held_pixels[i])
					held_off[i] = cfg_length > 0 ? clamp32(held_off[i] * ONE / cfg_length) : 0;
			end else if (i == 0) begin
				held_off[i] = 0;
				held_valued[i] = 1;
			end else if (n > 1 && i == n - 1) begin
				held_off[i] = ONE;
				held_valued[i] = 1;
			end
			if (held_valued[i]) begin
				if (have_prev && held_off[i] < prev)
					held_off[i] = prev;
				prev = held_off[i];
				have_prev = 1;
			end
		end
		// even spacing of missing runs
		if (n > 2) begin
			start = 0;
			in_run = 0;
			for (int i = 0; i < n; i++) begin
				if (!held_valued[i] && !in_run) begin
					start = i;
					in_run = 1;
				end else if (held_valued[i] && in_run) begin
					b = held_off[start-1];
					diff = held_off[i] - b;
					for (int j = start; j < i; j++) begin
						held_off[j] = b + diff * (j - start + 1) / (i - start + 1);
						held_valued[j] = 1;
					end
					in_run = 0;
				end
			end
		end
		// rescale to 0..1
		s0 = held_off[0];
		s1 = held_off[n-1];
		if (n >= 2 && (cfg_repeat || s0 < 0 || s1 > ONE)) begin
			resc = 1;
			span = s1 - s0;
			if (span > 0)
				for (int i = 0; i < n; i++) begin
					rel = held_off[i] - s0;
					if (rel < 0) rel = 0;
					held_off[i] = clamp32(rel * ONE / span);
				end
		end
		// emit with padding
		pre = held_off[0] > 0;
		post = held_off[n-1] < ONE;
		total = n + int'(pre) + int'(post);
		k = 0;
		if (pre) begin
			push_entry(0, held_col[0], k == total - 1, resc, s0, s1);
			k++;
		end
		for (int i = 0; i < n; i++) begin
			push_entry(held_off[i], held_col[i], k == total - 1, resc, s0, s1);
			k++;
		end
		if (post)
			push_entry(ONE, held_col[n-1], 1, resc, s0, s1);
	endfunction

	// prediction on every accepted stop transaction
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			if (list_empty) begin
				held_count = 0;
				push_entry(0, '0, 0, 0, 0, 0);
				push_entry(ONE, '0, 1, 0, 0, 0);
			end else begin
				if (held_count < grdcs_pkg::MAX_STOPS) begin
					held_off[held_count] = longint'(stop_offset);
					held_valued[held_count] = offset_given;
					held_pixels[held_count] = offset_in_pixels;
					held_col[held_count] = stop_color;
					held_count++;
				end
				if (last_stop && held_count > 0) begin
					resolve_stop_list();
					held_count = 0;
				end
			end
		end
	end

	// stop driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else if (in_valid && !in_ready) begin
			in_valid <= 1'b1;
		end else if (in_gap > 0) begin
			in_valid <= 1'b0;
			in_gap <= in_gap - 1;
		end else if (pending_stops.size() > 0) begin
			stop_item_t it;
			it = pending_stops.pop_front();
			stop_offset <= it.offset;
			offset_given <= it.given;
			offset_in_pixels <= it.pixels;
			stop_color <= it.col;
			list_empty <= it.empty;
			last_stop <= it.last;
			in_valid <= 1'b1;
			in_gap <= no_idle ? 0 : $urandom_range(0, 3);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// entry monitor and output stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else begin
			int nstall;
			color_entry_t e;
			nstall = out_stall;
			if (out_valid && out_ready) begin
				nstall = no_idle ? 0 : $urandom_range(0, 3);
				if (expected_entries.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("tb: unexpected entry pos=%h col=%h", position, color);
				end else begin
					e = expected_entries.pop_front();
					if (position !== e.pos || color !== e.col || last_entry !== e.last ||
							rescaled !== e.resc || span_start !== e.s0 || span_end !== e.s1) begin
						errors++;
						if (errors <= 10)
							$display("tb: mismatch exp %h %h %b %b %h %h got %h %h %b %b %h %h",
								e.pos, e.col, e.last, e.resc, e.s0, e.s1, position, color,
								last_entry, rescaled, span_start, span_end);
					end
				end
			end
			if (nstall > 0) begin
				out_ready <= 1'b0;
				out_stall <= nstall - 1;
			end else begin
				out_ready <= 1'b1;
				out_stall <= 0;
			end
		end
	end

	task automatic add_stop(logic signed [grdcs_pkg::OFF_W-1:0] off, bit given, bit pix,
			bit last);
		stop_item_t it;
		it.offset = off;
		it.given = given;
		it.pixels = pix;
		it.col = $urandom;
		it.empty = 1'b0;
		it.last = last;
		pending_stops.insert(pending_stops.size(), it);
	endtask

	task automatic add_empty();
		stop_item_t it;
		it.offset = $urandom;
		it.given = 1'($urandom);
		it.pixels = 1'($urandom);
		it.col = $urandom;
		it.empty = 1'b1;
		it.last = 1'($urandom);
		pending_stops.insert(pending_stops.size(), it);
	endtask

	// random list, mostly short, sometimes past capacity, sometimes broken
	task automatic add_random_list();
		int n;
		logic signed [grdcs_pkg::OFF_W-1:0] off;
		n = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: off = $urandom;
				1: off = $signed($urandom_range(0, 32'h18000)) - 32'sh4000;
				2: off = $urandom_range(0, 32'h200000);
				default: off = $urandom_range(0, 1) ? grdcs_pkg::FX_ONE : '0;
			endcase
			if (i == n - 1 && $urandom_range(0, 9) == 0) begin
				add_empty();
			end else begin
				add_stop(off, $urandom_range(0, 9) < 7, $urandom_range(0, 3) == 0, i == n - 1);
			end
		end
	endtask

	task automatic write_reg(logic [grdcs_pkg::CFG_IDX_W-1:0] idx,
			logic [grdcs_pkg::LEN_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == grdcs_pkg::REG_GRADIENT_LENGTH) cfg_length = longint'(val);
		else cfg_repeat = val[0];
	endtask

	task automatic drain();
		while (pending_stops.size() > 0 || in_valid || expected_entries.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic random_phase(logic [grdcs_pkg::LEN_W-1:0] len, bit rep, bit busy);
		int start_items;
		write_reg(grdcs_pkg::REG_GRADIENT_LENGTH, len);
		write_reg(grdcs_pkg::REG_REPEAT_MODE, grdcs_pkg::LEN_W'(rep));
		no_idle = busy;
		start_items = 0;
		while (start_items < 20) begin
			int before_n;
			before_n = pending_stops.size();
			add_random_list();
			start_items += pending_stops.size() - before_n;
		end
		drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// directed corner cases
		write_reg(grdcs_pkg::REG_GRADIENT_LENGTH, 31'd10 << grdcs_pkg::FRAC_BITS);
		write_reg(grdcs_pkg::REG_REPEAT_MODE, grdcs_pkg::LEN_W'(1'b0));
		add_empty();
		add_stop(32'sh8000, 1, 0, 1);
		add_stop(32'sh1234, 0, 0, 1);
		add_stop(32'sh80000000, 1, 0, 0);
		add_stop(32'sh7fffffff, 1, 1, 1);
		add_stop(0, 1, 0, 0);
		add_stop(0, 0, 0, 0);
		add_stop(0, 0, 0, 0);
		add_stop(32'sh50000, 1, 1, 1);
		add_stop(32'shcccc, 1, 0, 0);
		add_stop(32'sh3333, 1, 0, 0);
		add_stop(0, 0, 0, 1);
		add_stop(-32'sh8000, 1, 0, 0);
		add_stop(-32'sh8000, 1, 0, 1);
		add_stop(32'sh4000, 1, 0, 0);
		add_empty();
		drain();
		write_reg(grdcs_pkg::REG_GRADIENT_LENGTH, '0);
		write_reg(grdcs_pkg::REG_REPEAT_MODE, grdcs_pkg::LEN_W'(1'b1));
		add_stop(32'sh30000, 1, 1, 0);
		add_stop(32'sh4000, 1, 0, 0);
		add_stop(32'sh10000, 0, 0, 1);
		drain();
		// random phases across register settings
		random_phase('0, 1'b0, 1'b0);
		random_phase({grdcs_pkg::LEN_W{1'b1}}, 1'b1, 1'b0);
		random_phase(31'd100 << grdcs_pkg::FRAC_BITS, 1'b0, 1'b1);
		random_phase(grdcs_pkg::LEN_W'($urandom), 1'b1, 1'b0);
		random_phase(31'd3 << grdcs_pkg::FRAC_BITS, 1'b0, 1'b0);
		errors += expected_entries.size();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
